// File: rtl/core/payload_split_about_equally_assert.svh
// Assertion macros for the port-level checker of the payload splitter.
// Depends on nothing; include by bare file name.
`ifndef PAYLOAD_SPLIT_ABOUT_EQUALLY_ASSERT_SVH
`define PAYLOAD_SPLIT_ABOUT_EQUALLY_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PSAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PSAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/psae_pkg.sv
// Package of the payload splitter: widths, codes, register indexes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package psae_pkg;

  localparam int PAY_W      = 20;  // frame_bytes
  localparam int BYTES_W    = 16;  // packet_bytes
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int STAT_W     = 2;
  localparam int TOT_W      = PAY_W + 1;  // payload plus two reductions
  localparam int NPK_FULL_W = TOT_W + 1;  // ceil of total / capacity
  localparam int DIV_CNT_W  = $clog2(TOT_W);
  localparam int IN_DATA_W  = ((PAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((BYTES_W + 7) / 8) * 8;

  localparam int MAX_PACKETS_DEF = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REDUCTION  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_REDUCTION   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_REDUCTION = 2'd3;

  localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = 16'd1200;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CAP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FEW  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MANY = 2'd3;

  // what the output register is loaded with
  localparam logic [1:0] OUT_SINGLE = 2'd0;
  localparam logic [1:0] OUT_ERR    = 2'd1;
  localparam logic [1:0] OUT_STEP   = 2'd2;

  // divisor select
  localparam logic DIV_BY_CAP = 1'b0;
  localparam logic DIV_BY_NPK = 1'b1;

  typedef struct packed {
    logic              load_in;
    logic              div_start;
    logic              div_sel;
    logic              latch_npk;
    logic              init_emit;
    logic              out_load;
    logic [1:0]        out_kind;
    logic [STAT_W-1:0] err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic fast_fit;
    logic cap_bad;
    logic few_bytes;
    logic too_many;
    logic div_done;
    logic emit_last;
  } dp_stat_t;

endpackage

// File: rtl/core/psae_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on psae_pkg.
`timescale 1ns / 1ps

module psae_div import psae_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [TOT_W-1:0]   dividend,
  input  logic [CFG_W-1:0]   divisor,
  output logic [TOT_W-1:0]   quotient,
  output logic [CFG_W-1:0]   remainder,
  output logic               done
);

  logic [TOT_W-1:0]     quo_r, quo_nxt;
  logic [CFG_W-1:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CFG_W:0]       shifted;
  logic [CFG_W:0]       diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[TOT_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[TOT_W-2:0], ge};
      rem_nxt = ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(TOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// File: rtl/core/psae_dp.sv
// Datapath of the payload splitter: config registers, frame checks, shared
// divider, packet size step and output register. Depends on psae_pkg, psae_div.
`timescale 1ns / 1ps

module psae_dp import psae_pkg::*; #(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [PAY_W-1:0]     frame_bytes,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [BYTES_W-1:0]   packet_bytes,
  output logic                 last,
  output logic [STAT_W-1:0]    status
);

  localparam int CNT_W = $clog2(MAX_PACKETS + 1);
  localparam int NPK_W = CNT_W + 1;  // two's complement, may run below zero

  logic [CFG_W-1:0]      cap_r, fr_r, lr_r, sr_r;
  logic [PAY_W-1:0]      payload_r;
  logic [NPK_FULL_W-1:0] npk_full_r, npk_full_nxt;
  logic [TOT_W-1:0]      per_r, per_nxt;
  logic [CNT_W-1:0]      larger_r, larger_nxt;
  logic [PAY_W-1:0]      remain_r, remain_nxt;
  logic [NPK_W-1:0]      npk_r, npk_nxt;
  logic                  first_r, first_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [BYTES_W-1:0]    out_bytes_r, out_bytes_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;

  logic [TOT_W-1:0]      total;
  logic [TOT_W-1:0]      div_quo;
  logic [CFG_W-1:0]      div_rem;
  logic [CFG_W-1:0]      div_dsr;
  logic [NPK_FULL_W-1:0] npk_calc;
  logic [TOT_W-1:0]      per_inc, cur_a, cur_b, cur_c;
  logic [PAY_W-1:0]      remain_step;
  logic [CNT_W-1:0]      count_inc;
  logic                  emit_last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= MAX_PAYLOAD_RST;
      fr_r  <= '0;
      lr_r  <= '0;
      sr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD:      cap_r <= cfg_wdata;
        CFG_FIRST_REDUCTION:  fr_r  <= cfg_wdata;
        CFG_LAST_REDUCTION:   lr_r  <= cfg_wdata;
        CFG_SINGLE_REDUCTION: sr_r  <= cfg_wdata;
      endcase
    end
  end

  assign total = TOT_W'(payload_r) + TOT_W'(fr_r) + TOT_W'(lr_r);

  assign div_dsr = (cmd.div_sel == DIV_BY_NPK) ? npk_full_r[CFG_W-1:0] : cap_r;

  psae_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (total),
    .divisor   (div_dsr),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (stat.div_done)
  );

  // packet count is the ceiling of total / capacity, two at least
  always_comb begin
    npk_calc = NPK_FULL_W'(div_quo) + NPK_FULL_W'(div_rem != '0);
    if (npk_calc == NPK_FULL_W'(1)) begin
      npk_calc = NPK_FULL_W'(2);
    end
  end

  assign stat.fast_fit  = (payload_r == '0) ||
                          (TOT_W'(cap_r) >= TOT_W'(sr_r) + TOT_W'(payload_r));
  assign stat.cap_bad   = (cap_r <= fr_r) || (cap_r <= lr_r);
  assign stat.few_bytes = NPK_FULL_W'(payload_r) < npk_full_r;
  assign stat.too_many  = npk_full_r > NPK_FULL_W'(MAX_PACKETS);

  // one packet size per step
  always_comb begin
    per_inc = (npk_r == {1'b0, larger_r}) ? per_r + 1'b1 : per_r;
    if (first_r) begin
      cur_a = (per_inc > TOT_W'(fr_r) + 1'b1) ? per_inc - TOT_W'(fr_r) : TOT_W'(1);
    end else begin
      cur_a = per_inc;
    end
    cur_b = (cur_a > TOT_W'(remain_r)) ? TOT_W'(remain_r) : cur_a;
    // keep one byte back for the final packet
    if (npk_r == NPK_W'(2) && cur_b == TOT_W'(remain_r)) begin
      cur_c = cur_b - 1'b1;
    end else begin
      cur_c = cur_b;
    end
    remain_step = remain_r - cur_c[PAY_W-1:0];
    count_inc   = count_r + 1'b1;
    emit_last   = (remain_step == '0) || (count_inc >= CNT_W'(MAX_PACKETS));
  end

  assign stat.emit_last = emit_last;

  always_comb begin
    npk_full_nxt   = npk_full_r;
    per_nxt        = per_r;
    larger_nxt     = larger_r;
    remain_nxt     = remain_r;
    npk_nxt        = npk_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    out_bytes_nxt  = out_bytes_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    if (cmd.latch_npk) begin
      npk_full_nxt = npk_calc;
    end
    if (cmd.init_emit) begin
      per_nxt    = div_quo;
      larger_nxt = div_rem[CNT_W-1:0];
      remain_nxt = payload_r;
      npk_nxt    = npk_full_r[NPK_W-1:0];
      first_nxt  = 1'b1;
      count_nxt  = '0;
    end
    if (cmd.out_load) begin
      unique case (cmd.out_kind)
        OUT_SINGLE: begin
          out_bytes_nxt  = payload_r[BYTES_W-1:0];
          out_last_nxt   = 1'b1;
          out_status_nxt = STAT_OK;
        end
        OUT_ERR: begin
          out_bytes_nxt  = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = cmd.err_code;
        end
        OUT_STEP: begin
          out_bytes_nxt  = cur_c[BYTES_W-1:0];
          out_last_nxt   = emit_last;
          out_status_nxt = STAT_OK;
          per_nxt        = per_inc;
          remain_nxt     = remain_step;
          npk_nxt        = npk_r - 1'b1;
          first_nxt      = 1'b0;
          count_nxt      = count_inc;
        end
        default: begin
          out_bytes_nxt = out_bytes_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      payload_r <= frame_bytes;
    end
    npk_full_r   <= npk_full_nxt;
    per_r        <= per_nxt;
    larger_r     <= larger_nxt;
    remain_r     <= remain_nxt;
    npk_r        <= npk_nxt;
    first_r      <= first_nxt;
    count_r      <= count_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign packet_bytes = out_bytes_r;
  assign last         = out_last_r;
  assign status       = out_status_r;

endmodule

// File: rtl/core/psae_ctrl.sv
// Controller of the payload splitter: sequences checks, the two divisions
// and packet emission; owns the handshakes. Depends on psae_pkg.
`timescale 1ns / 1ps

module psae_ctrl import psae_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_CHK2 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // output register free, or its word leaves this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load_in = (state_r == S_IDLE) && in_valid;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (stat.fast_fit) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_SINGLE;
            state_nxt    = S_IDLE;
          end
        end else if (stat.cap_bad) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_ERR;
            cmd.err_code = STAT_CAP;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_BY_CAP;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.latch_npk = 1'b1;
          state_nxt     = S_CHK2;
        end
      end
      S_CHK2: begin
        priority if (stat.few_bytes) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_ERR;
            cmd.err_code = STAT_FEW;
            state_nxt    = S_IDLE;
          end
        end else if (stat.too_many) begin
          if (slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = OUT_ERR;
            cmd.err_code = STAT_MANY;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_BY_NPK;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_sel = DIV_BY_NPK;
        if (stat.div_done) begin
          cmd.init_emit = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_STEP;
          if (stat.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/payload_split_about_equally.sv
// Payload splitter, top level. Takes one frame length a word and returns the
// sizes of the packets that carry it, about equal, one word per packet.
//   in_*  : frame length words; accepted when in_tvalid and in_tready are high.
//   out_* : packet words; tlast marks the final word of a frame, tuser the
//           status (nonzero: error, single word with zero bytes and tlast).
//   cfg_* : register writes (capacity and the three reductions), only while idle.
// Timing: one frame at a time. After acceptance the checks are made in S_CHK;
// a frame that fits, or a capacity error, goes from there into the output
// register once that register is free. Otherwise the shared one-bit-a-cycle
// divider computes total / capacity and then, if the packet count passes its
// checks, total / packet count; packet words then follow one per cycle while
// the receiver takes them. When the receiver stalls, the output register
// holds its word and packet generation waits; in_tready returns as soon as
// the last word of a frame is loaded, even if it has not been taken yet.
// Reset (rst_n low, synchronous) empties the output and restores the
// registers: capacity 1200, reductions zero.
// Depends on psae_pkg, psae_ctrl, psae_dp.
`timescale 1ns / 1ps

module payload_split_about_equally import psae_pkg::*; #(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [19:0] frame_bytes
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] packet_bytes
  output logic                  out_tlast,
  output logic [STAT_W-1:0]     out_tuser   // [1:0] status
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [BYTES_W-1:0] packet_bytes;

  psae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psae_dp #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .frame_bytes  (in_tdata[PAY_W-1:0]),
    .cmd          (cmd),
    .stat         (stat),
    .packet_bytes (packet_bytes),
    .last         (out_tlast),
    .status       (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(packet_bytes);

endmodule

// File: rtl/core/psae_checker.sv
// Port-level checker of the payload splitter, bound to the top level.
// Depends on psae_pkg and payload_split_about_equally_assert.svh.
`timescale 1ns / 1ps
`include "payload_split_about_equally_assert.svh"

module psae_checker import psae_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic [STAT_W-1:0]     out_tuser
);

  `PSAE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output word changed")

  `PSAE_ASSERT_NOW(a_err_word, clk, rst_n, out_tvalid && (out_tuser != STAT_OK), (out_tdata == '0) && out_tlast, "error word without zero bytes and tlast")

  `PSAE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "second frame taken before the first was checked")

  `PSAE_ASSERT_NOW(a_empty_after_reset, clk, rst_n, $past(rst_n) == 1'b0, !out_tvalid, "output word present right after reset")

endmodule

bind payload_split_about_equally psae_checker u_psae_checker (.*);

// File: dv/tb.sv
// Self-checking bench for payload_split_about_equally: frame lengths go in,
// packet sizes are predicted in a scoreboard class and compared word by word.
// Depends on psae_pkg and the splitter RTL only.
`timescale 1ns / 1ps

module tb;
  import psae_pkg::*;

  localparam int     MAX_PKTS    = MAX_PACKETS_DEF;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     TX_GAP_MAX  = 17;
  localparam int     RX_GAP_MAX  = 17;
  localparam int     HOLD_CYCLES = 600;
  localparam int     SETTLE      = 4;
  localparam int     MAX_PRINTS  = 50;
  localparam longint PAY_MAX     = (64'd1 << PAY_W) - 1;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic               fin;
    logic [STAT_W-1:0]  st;
  } packet_t;

  class split_scoreboard;
    longint  cap;
    longint  first_red;
    longint  last_red;
    longint  single_red;
    packet_t sizes_q[$];
    int      errors;
    int      frames;
    int      words;

    function new();
      cap        = longint'(MAX_PAYLOAD_RST);
      first_red  = 0;
      last_red   = 0;
      single_red = 0;
      errors     = 0;
      frames     = 0;
      words      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MAX_PAYLOAD:      cap        = longint'(val);
        CFG_FIRST_REDUCTION:  first_red  = longint'(val);
        CFG_LAST_REDUCTION:   last_red   = longint'(val);
        CFG_SINGLE_REDUCTION: single_red = longint'(val);
        default: ;
      endcase
    endfunction

    function void push_size(longint b, bit fin, logic [STAT_W-1:0] st);
      packet_t p;
      p.bytes = b[BYTES_W-1:0];
      p.fin   = fin;
      p.st    = st;
      sizes_q.insert(sizes_q.size(), p);
    endfunction

    // splits one accepted frame into its expected packet words
    function void note_frame(logic [PAY_W-1:0] fb);
      longint pay, total, npk, per, larger, remain, cur;
      int     n;
      bit     first;
      pay = longint'(fb);
      frames++;
      if (pay == 0 || cap >= single_red + pay) begin
        push_size(pay, 1'b1, STAT_OK);
        return;
      end
      if (cap - first_red < 1 || cap - last_red < 1) begin
        push_size(0, 1'b1, STAT_CAP);
        return;
      end
      total = pay + first_red + last_red;
      npk   = (total + cap - 1) / cap;
      if (npk == 1) npk = 2;
      if (pay < npk) begin
        push_size(0, 1'b1, STAT_FEW);
        return;
      end
      if (npk > MAX_PKTS) begin
        push_size(0, 1'b1, STAT_MANY);
        return;
      end
      per    = total / npk;
      larger = total % npk;
      remain = pay;
      n      = 0;
      first  = 1'b1;
      while (remain > 0 && n < MAX_PKTS) begin
        // the trailing "larger" packets carry one extra byte
        if (npk == larger) per++;
        cur = per;
        if (first) cur = (cur > first_red + 1) ? cur - first_red : 1;
        if (cur > remain) cur = remain;
        // keep a byte back for the final packet
        if (npk == 2 && cur == remain) cur--;
        remain -= cur;
        npk--;
        first = 1'b0;
        push_size(cur, (remain <= 0 || n + 1 >= MAX_PKTS), STAT_OK);
        n++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("tb: mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_packet(logic [BYTES_W-1:0] bytes, logic fin, logic [STAT_W-1:0] st);
      packet_t e;
      words++;
      if (sizes_q.size() == 0) begin
        report($sformatf("word %0d/%0d/%0d with nothing pending", bytes, fin, st));
        return;
      end
      e = sizes_q.pop_front();
      if (bytes !== e.bytes)
        report($sformatf("packet_bytes %0d, want %0d", bytes, e.bytes));
      if (fin !== e.fin)
        report($sformatf("last %0b, want %0b (bytes %0d)", fin, e.fin, e.bytes));
      if (st !== e.st)
        report($sformatf("status %0d, want %0d", st, e.st));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MAX_PAYLOAD;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [STAT_W-1:0]     out_tuser;

  split_scoreboard sb = new();
  longint cycles      = 0;
  bit     tx_idle     = 1'b1;
  bit     rx_idle     = 1'b1;
  bit     hold_req    = 1'b0;
  int     settings_seen = 0;

  payload_split_about_equally #(.MAX_PACKETS(MAX_PKTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d words pending", cycles, sb.sizes_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_frame(in_tdata[PAY_W-1:0]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_packet(out_tdata[BYTES_W-1:0], out_tlast, out_tuser);
  end

  // result side: random stalls per word while rx_idle is set, plus an occasional long hold-off
  initial begin : rx_side
    int w;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = rx_idle ? $urandom_range(0, RX_GAP_MAX) : 0;
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // valid stays up across back-to-back words; it only drops for a gap
  task send_frame(input logic [PAY_W-1:0] fb);
    int gap;
    gap = tx_idle ? $urandom_range(0, TX_GAP_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - PAY_W){1'b0}}, fb};
    do @(posedge clk); while (!in_tready);
  endtask

  // first let the frame taken at the last edge be noted by the scoreboard
  task wait_idle;
    @(posedge clk);
    while (sb.sizes_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task apply_config(input logic [CFG_W-1:0] c, f, l, s);
    logic [CFG_W-1:0]     vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    vals = '{c, f, l, s};
    idxs = '{CFG_MAX_PAYLOAD, CFG_FIRST_REDUCTION, CFG_LAST_REDUCTION, CFG_SINGLE_REDUCTION};
    in_tvalid <= 1'b0;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      sb.write_reg(idxs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // mostly lengths that split into 2..64 packets; some boundaries, fits and noise
  function automatic logic [PAY_W-1:0] pick_frame(longint c, longint f, longint l, longint s);
    longint n, v;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      n = longint'($urandom_range(2, MAX_PKTS));
      v = (n - 1) * c + longint'($urandom_range(1, int'(c))) - f - l;
      if (v < 1) v = longint'($urandom_range(1, int'(c) + 1));
    end else if (r < 70) begin
      n = longint'($urandom_range(1, MAX_PKTS + 1));
      v = n * c - f - l + longint'($urandom_range(0, 2)) - 1;
    end else if (r < 80) begin
      v = longint'($urandom_range(0, int'(c + s)));
    end else begin
      v = longint'($urandom_range(0, int'(PAY_MAX)));
    end
    if (v < 0) v = 0;
    if (v > PAY_MAX) v = PAY_MAX;
    return v[PAY_W-1:0];
  endfunction

  initial begin : main_seq
    logic [CFG_W-1:0] c, f, l, s;
    int n_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty frame, fit edges, 2 and 64 packets, too many
    send_frame(0);
    send_frame(1);
    send_frame(1199);
    send_frame(1200);
    send_frame(1201);
    send_frame(2400);
    send_frame(2401);
    send_frame(76800);
    send_frame(76801);
    send_frame('1);
    // single reduction edge, reductions on a split
    apply_config(1200, 100, 50, 30);
    send_frame(1170);
    send_frame(1171);
    send_frame(2000);
    // more packets than bytes; first packet clamped to one byte
    apply_config(100, 99, 99, 100);
    send_frame(1);
    send_frame(10);
    // one-byte packets: 64 is the most, 65 too many
    apply_config(1, 0, 0, 0);
    send_frame(2);
    send_frame(64);
    send_frame(65);
    apply_config(16'hFFFF, 0, 0, 16'hFFFF);
    send_frame(1);
    send_frame('1);
    // zero capacity, then capacity eaten by either reduction
    apply_config(0, 0, 0, 0);
    send_frame(0);
    send_frame(5);
    apply_config(5, 5, 0, 0);
    send_frame(100);
    apply_config(5, 0, 5, 0);
    send_frame(100);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: {c, f, l, s} = {16'd1200, 16'd0, 16'd0, 16'd0};
        1: {c, f, l, s} = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: {c, f, l, s} = {16'd1, 16'd0, 16'd0, 16'd0};
        3: {c, f, l, s} = {16'hFFFF, 16'd0, 16'd0, 16'd0};
        default: begin
          c = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(1, 65535))
                                          : CFG_W'($urandom_range(2, 3000));
          f = CFG_W'($urandom_range(0, c / 2));
          l = CFG_W'($urandom_range(0, c / 2));
          s = CFG_W'($urandom_range(0, c));
        end
      endcase
      apply_config(c, f, l, s);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (p == 0 || p == 5) hold_req = 1'b1;
      n_items = (p == 1) ? 10 : 49;
      for (int k = 0; k < n_items; k++) send_frame(pick_frame(c, f, l, s));
    end
    in_tvalid <= 1'b0;
    wait_idle();

    $display("tb: %0d frames split into %0d packet words under %0d register settings",
             sb.frames, sb.words, settings_seen);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
